FILE: design/assert_macros.svh
// Assertion helpers shared by the design files.
// Every property samples on the rising edge of clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dba7_pkg.sv
package dba7_pkg;

    localparam int BUTTON_COUNT = 8;
    localparam int HIST_W       = 13;
    localparam int SUM_W        = 10;
    localparam int SEG_W        = 8;

    // One released sample followed by twelve pressed samples.
    localparam logic [HIST_W-1:0] HIST_PRESS = 13'h1000;
    localparam logic [SUM_W-1:0]  SUM_LIMIT  = 10'd1023;
    localparam logic [SEG_W-1:0]  SEG_BLANK  = 8'hFF;

    // Active-low DP G F E D C B A codes for digits 0 to 9.
    localparam logic [SEG_W-1:0] SEG_CODES [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
        8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    typedef struct packed {
        logic [SEG_W-1:0] ones;
        logic [SEG_W-1:0] tens;
        logic [SEG_W-1:0] hundreds;
        logic [SEG_W-1:0] thousands;
    } seg_word_t;

    function automatic logic [SEG_W-1:0] digit_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        code = SEG_BLANK;
        if (digit < 4'd10)
        begin
            code = SEG_CODES[digit];
        end
        return code;
    endfunction

endpackage

FILE: design/dba7_seg_decode.sv
// Split a sum of 0..1023 into decimal digits and blank leading zeros.
module dba7_seg_decode (
    input  logic [dba7_pkg::SUM_W-1:0] sum,
    output dba7_pkg::seg_word_t        segs
);

    logic       thousand;
    logic [9:0] rem_hundreds;
    logic [3:0] hundreds;
    logic [6:0] rem_tens;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [9:0] hundreds_part;
    logic [6:0] tens_part;

    always_comb
    begin
        thousand     = (sum >= 10'd1000);
        rem_hundreds = thousand ? (sum - 10'd1000) : sum;

        // Parallel threshold compares, highest match wins.
        hundreds = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem_hundreds >= 10'(k * 100))
            begin
                hundreds = 4'(k);
            end
        end
        hundreds_part = ({6'd0, hundreds} << 6) + ({6'd0, hundreds} << 5)
                      + ({6'd0, hundreds} << 2);
        rem_tens      = 7'(rem_hundreds - hundreds_part);

        tens = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem_tens >= 7'(k * 10))
            begin
                tens = 4'(k);
            end
        end
        tens_part = ({3'd0, tens} << 3) + ({3'd0, tens} << 1);
        ones      = 4'(rem_tens - tens_part);

        segs.ones      = dba7_pkg::digit_code(ones);
        segs.tens      = (sum < 10'd10)   ? dba7_pkg::SEG_BLANK : dba7_pkg::digit_code(tens);
        segs.hundreds  = (sum < 10'd100)  ? dba7_pkg::SEG_BLANK
                                          : dba7_pkg::digit_code(hundreds);
        segs.thousands = thousand ? dba7_pkg::SEG_CODES[1] : dba7_pkg::SEG_BLANK;
    end

endmodule

FILE: design/debounced_button_adder_7seg.sv
// Debounced button adder with four-digit seven-segment codes.
// Input channel (in_valid / in_stall / raw_buttons): one word per scan tick,
// eight active-low button levels. Each button keeps a 13-sample history; a
// press counts once, when one released sample is followed by twelve pressed
// ones, and adds 2^i to the running sum. Sums above 1023 wrap modulo 1023.
// Output channel (out_valid / out_stall): one word per input word, with the
// sum and active-low DP..A codes for ones, tens, hundreds and thousands;
// leading digits read 0xFF (blank), the ones digit always shows.
// Path: the history update and sum are registered in the sum stage at the
// accept edge; the digit decode is then registered into the output register,
// which raises out_valid. Throughput: one word per cycle while out_stall is
// low, set by the two-register pipeline with no shared unit.
// Reset: histories and sum clear to zero, both pipeline stages empty. A
// button held down since reset is not counted until it is seen released.
// Stall: out_stall holds the output word; the sum stage then fills and
// in_stall rises in the same cycle, so no word is dropped or repeated.
`include "assert_macros.svh"

module debounced_button_adder_7seg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           raw_buttons,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [dba7_pkg::SUM_W-1:0]           sum_value,
    output logic [dba7_pkg::SEG_W-1:0]           seg_ones,
    output logic [dba7_pkg::SEG_W-1:0]           seg_tens,
    output logic [dba7_pkg::SEG_W-1:0]           seg_hundreds,
    output logic [dba7_pkg::SEG_W-1:0]           seg_thousands
);

    logic [dba7_pkg::HIST_W-1:0]       history_reg [dba7_pkg::BUTTON_COUNT];
    logic [dba7_pkg::HIST_W-1:0]       history_next [dba7_pkg::BUTTON_COUNT];
    logic [dba7_pkg::BUTTON_COUNT-1:0] press_vec;
    logic [dba7_pkg::SUM_W:0]          sum_wide;
    logic [dba7_pkg::SUM_W-1:0]        running_sum_reg;
    logic [dba7_pkg::SUM_W-1:0]        running_sum_next;
    logic                              sum_valid_reg;
    logic                              out_valid_reg;
    logic [dba7_pkg::SUM_W-1:0]        sum_value_reg;
    dba7_pkg::seg_word_t               segs_reg;
    dba7_pkg::seg_word_t               segs_next;
    logic                              in_accept;
    logic                              out_free;
    logic                              sum_move;

    // Handshake: the output register frees when empty or being taken;
    // the sum stage takes a word when empty or moving on.
    assign out_free  = !out_valid_reg || !out_stall;
    assign sum_move  = sum_valid_reg && out_free;
    assign in_stall  = sum_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Shift in the new level (1 = released) and detect the press pattern.
    // Each reported button adds a distinct power of two, so the total of
    // this tick's presses is simply the press vector read as a number.
    always_comb
    begin
        for (int i = 0; i < dba7_pkg::BUTTON_COUNT; i++)
        begin
            history_next[i] = {history_reg[i][dba7_pkg::HIST_W-2:0], raw_buttons[i]};
            press_vec[i]    = (history_next[i] == dba7_pkg::HIST_PRESS);
        end
        sum_wide = {1'b0, running_sum_reg} + (dba7_pkg::SUM_W + 1)'(press_vec);
        // Below twice the limit, so one subtract does the modulo.
        if (sum_wide > {1'b0, dba7_pkg::SUM_LIMIT})
        begin
            running_sum_next = dba7_pkg::SUM_W'(sum_wide - {1'b0, dba7_pkg::SUM_LIMIT});
        end
        else
        begin
            running_sum_next = sum_wide[dba7_pkg::SUM_W-1:0];
        end
    end

    // Sum stage: history and running sum advance on every accepted word.
    // The running sum register doubles as this stage's payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dba7_pkg::BUTTON_COUNT; i++)
            begin
                history_reg[i] <= '0;
            end
            running_sum_reg <= '0;
            sum_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                for (int i = 0; i < dba7_pkg::BUTTON_COUNT; i++)
                begin
                    history_reg[i] <= history_next[i];
                end
                running_sum_reg <= running_sum_next;
                sum_valid_reg   <= 1'b1;
            end
            else if (sum_move)
            begin
                sum_valid_reg <= 1'b0;
            end
        end
    end

    dba7_seg_decode u_seg_decode (
        .sum  (running_sum_reg),
        .segs (segs_next)
    );

    // Output stage: load the decoded word when free, drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_move)
        begin
            sum_value_reg <= running_sum_reg;
            segs_reg      <= segs_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sum_value     = sum_value_reg;
    assign seg_ones      = segs_reg.ones;
    assign seg_tens      = segs_reg.tens;
    assign seg_hundreds  = segs_reg.hundreds;
    assign seg_thousands = segs_reg.thousands;

    `ASSERT_NEXT(a_idle_tick_keeps_sum, in_accept && (press_vec == '0), running_sum_reg == $past(running_sum_reg), "sum changed on a tick without a press")
    `ASSERT_NEXT(a_sum_fills_empty_out, sum_valid_reg && !out_valid_reg, out_valid_reg, "sum word did not move into an empty output register")
    `ASSERT_IMPLIES(a_thousands_digit, out_valid_reg && (sum_value_reg >= 10'd1000), seg_thousands == dba7_pkg::SEG_CODES[1], "thousands digit wrong")
    `ASSERT_IMPLIES(a_small_sum_blank, out_valid_reg && (sum_value_reg < 10'd10), (seg_tens == dba7_pkg::SEG_BLANK) && (seg_hundreds == dba7_pkg::SEG_BLANK), "leading digits not blanked")

endmodule

FILE: dv/tb_debounced_button_adder_7seg.sv
`timescale 1ns / 100ps

module tb_debounced_button_adder_7seg;

    localparam int CLK_HALF    = 6;
    localparam int RESET_TICKS = 10;
    localparam int RANDOM_SCANS = 600;
    // Worst case is roughly 625 words, each behind the longest idle gap and the
    // longest stall; allow several times that.
    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_TICKS = 8;

    // One display readout as the block should present it.
    typedef struct {
        logic [dba7_pkg::SUM_W-1:0] sum;
        logic [dba7_pkg::SEG_W-1:0] ones;
        logic [dba7_pkg::SEG_W-1:0] tens;
        logic [dba7_pkg::SEG_W-1:0] hundreds;
        logic [dba7_pkg::SEG_W-1:0] thousands;
    } readout_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [7:0]                 raw_buttons;
    logic                       out_valid;
    logic                       out_stall;
    logic [dba7_pkg::SUM_W-1:0] sum_value;
    logic [dba7_pkg::SEG_W-1:0] seg_ones;
    logic [dba7_pkg::SEG_W-1:0] seg_tens;
    logic [dba7_pkg::SEG_W-1:0] seg_hundreds;
    logic [dba7_pkg::SEG_W-1:0] seg_thousands;

    // Scan words waiting to be driven, and readouts waiting to come back.
    logic [7:0]  pending_scans[$];
    readout_t    expected_readouts[$];

    // Predictor state: per-button sample history and the running total.
    logic [dba7_pkg::HIST_W-1:0] button_hist[dba7_pkg::BUTTON_COUNT];
    logic [dba7_pkg::SUM_W-1:0]  running_total;

    logic word_taken;
    int   scan_gap;
    int   stall_left;
    int   cycle_count;
    int   error_count;

    debounced_button_adder_7seg i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .raw_buttons   (raw_buttons),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sum_value     (sum_value),
        .seg_ones      (seg_ones),
        .seg_tens      (seg_tens),
        .seg_hundreds  (seg_hundreds),
        .seg_thousands (seg_thousands)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Active-low DP G F E D C B A pattern for one decimal digit.
    function automatic logic [dba7_pkg::SEG_W-1:0] digit_segments(input int d);
        case (d)
            0:       return 8'hC0;
            1:       return 8'hF9;
            2:       return 8'hA4;
            3:       return 8'hB0;
            4:       return 8'h99;
            5:       return 8'h92;
            6:       return 8'h82;
            7:       return 8'hF8;
            8:       return 8'h80;
            9:       return 8'h90;
            default: return dba7_pkg::SEG_BLANK;
        endcase
    endfunction

    // Advance every button history by one scan tick, add the weight of each
    // button that just completed a debounced press, wrap, and decode digits.
    function automatic readout_t tally_tick(input logic [7:0] levels);
        readout_t                    r;
        int                          total;
        logic [dba7_pkg::HIST_W-1:0] h;
        total = running_total;
        for (int b = 0; b < dba7_pkg::BUTTON_COUNT; b++)
        begin
            h = {button_hist[b][dba7_pkg::HIST_W-2:0], levels[b]};
            button_hist[b] = h;
            // Released once, then pressed for twelve ticks: count it once.
            if (h == dba7_pkg::HIST_PRESS)
            begin
                total += (1 << b);
            end
        end
        // A total of exactly the limit stays; only totals above it wrap.
        if (total > dba7_pkg::SUM_LIMIT)
        begin
            total = total % dba7_pkg::SUM_LIMIT;
        end
        running_total = total[dba7_pkg::SUM_W-1:0];
        r.sum         = running_total;
        r.ones        = digit_segments(total % 10);
        r.tens        = (total < 10)   ? dba7_pkg::SEG_BLANK
                                       : digit_segments((total / 10) % 10);
        r.hundreds    = (total < 100)  ? dba7_pkg::SEG_BLANK
                                       : digit_segments((total / 100) % 10);
        r.thousands   = (total < 1000) ? dba7_pkg::SEG_BLANK
                                       : digit_segments((total / 1000) % 10);
        return r;
    endfunction

    // Mostly no idling, some short gaps, a few long ones. Whenever bits 8:7 of
    // the cycle count are both set, a calm stretch turns idling off altogether.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (cycle_count[8:7] == 2'b11)
        begin
            return 0;
        end
        if (pick < 70)
        begin
            return 0;
        end
        if (pick < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic check_field(input string what, input logic [dba7_pkg::SUM_W-1:0] want,
                               input logic [dba7_pkg::SUM_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            error_count++;
        end
    endtask

    // Sample both handshakes at the rising edge. Inputs only move on the
    // falling edge, so every value read here is settled.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        word_taken  <= rst_n && in_valid && !in_stall;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            if (rst_n && in_valid && !in_stall)
            begin
                expected_readouts.push_back(tally_tick(raw_buttons));
            end
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_readouts.size() == 0)
                begin
                    $display("%0t: unexpected readout, expected none, actual sum %0d",
                             $time, sum_value);
                    error_count++;
                end
                else
                begin
                    readout_t want;
                    want = expected_readouts.pop_front();
                    check_field("sum_value", want.sum, sum_value);
                    check_field("seg_ones", dba7_pkg::SUM_W'(want.ones),
                                dba7_pkg::SUM_W'(seg_ones));
                    check_field("seg_tens", dba7_pkg::SUM_W'(want.tens),
                                dba7_pkg::SUM_W'(seg_tens));
                    check_field("seg_hundreds", dba7_pkg::SUM_W'(want.hundreds),
                                dba7_pkg::SUM_W'(seg_hundreds));
                    check_field("seg_thousands", dba7_pkg::SUM_W'(want.thousands),
                                dba7_pkg::SUM_W'(seg_thousands));
                end
            end
        end
    end

    // Scan driver: hold the word until it is taken, then idle or load the
    // next one. Everything changes on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || word_taken))
        begin
            if (scan_gap > 0)
            begin
                in_valid <= 1'b0;
                scan_gap <= scan_gap - 1;
            end
            else if (pending_scans.size() != 0)
            begin
                in_valid    <= 1'b1;
                raw_buttons <= pending_scans.pop_front();
                scan_gap    <= idle_length();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Readout side: stall in bursts, with the stall released between bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= idle_length();
            end
        end
    end

    initial
    begin
        int         run_left[dba7_pkg::BUTTON_COUNT];
        logic [7:0] level;
        int         pick;

        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        raw_buttons   = 8'hFF;
        out_stall     = 1'b0;
        word_taken    = 1'b0;
        scan_gap      = 0;
        stall_left    = 0;
        cycle_count   = 0;
        error_count   = 0;
        running_total = '0;
        for (int b = 0; b < dba7_pkg::BUTTON_COUNT; b++)
        begin
            button_hist[b] = '0;
            run_left[b]    = 0;
        end

        // Hold every button from reset: a fresh history never reports these.
        repeat (12) pending_scans.push_back(8'h00);
        // Release all once, then hold all twelve ticks: all eight report on
        // the same tick and add together.
        pending_scans.push_back(8'hFF);
        repeat (12) pending_scans.push_back(8'h00);

        // Random part: each button runs its own press/release pattern, mostly
        // clean presses of twelve ticks or more, some too short to count,
        // some long holds. A few ticks are pure noise.
        level = 8'hFF;
        for (int n = 0; n < RANDOM_SCANS; n++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                pending_scans.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                for (int b = 0; b < dba7_pkg::BUTTON_COUNT; b++)
                begin
                    if (run_left[b] == 0)
                    begin
                        level[b] = !level[b];
                        if (level[b])
                        begin
                            run_left[b] = $urandom_range(1, 4);
                        end
                        else
                        begin
                            pick = $urandom_range(0, 9);
                            run_left[b] = (pick < 7) ? $urandom_range(12, 18) :
                                          (pick < 9) ? $urandom_range(3, 11) :
                                                       $urandom_range(19, 40);
                        end
                    end
                    run_left[b]--;
                end
                pending_scans.push_back(level);
            end
        end

        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all scans taken, all readouts back, then a short quiet tail
        // to catch any stray readout.
        while (pending_scans.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_readouts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_TICKS) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
